FILE: design/lars_pkg.sv
// shared types and constants for the local alignment row scorer
package lars_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;
    localparam logic [1:0] CFG_COLS     = 2'd3;

    localparam int CFG_DATA_BITS = 11;
    localparam int SYM_BITS      = 8;
    localparam int ROW_BITS      = 16;

    // configuration reset values
    localparam logic signed [7:0] MATCH_RESET    = 8'sd3;
    localparam logic signed [7:0] MISMATCH_RESET = -8'sd3;
    localparam logic signed [7:0] GAP_RESET      = -8'sd2;
    localparam logic [CFG_DATA_BITS-1:0] COLS_RESET = 11'd1024;

    localparam logic [ROW_BITS-1:0] ROW_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_LEFT = 2'd2,
        DIR_DIAG = 2'd3
    } dir_t;

    // per-item control flags from the indexer to the cell datapath
    typedef struct packed {
        logic fresh;      // first cell of a new matrix
        logic col_zero;   // first cell of a row
        logic row_first;  // row 1: nothing above
    } cell_ctl_t;

endpackage

FILE: design/lars_indexer.sv
// row and column bookkeeping for each accepted item
module lars_indexer #(
    parameter int MAX_COLS = 1024,
    parameter int COL_W    = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                new_matrix,
    input  logic [lars_pkg::CFG_DATA_BITS-1:0]  cols_in_use,
    output logic [COL_W-1:0]                    col,
    output logic [lars_pkg::ROW_BITS-1:0]       row,
    output lars_pkg::cell_ctl_t                 ctl
);

    logic [COL_W-1:0]              col_reg, col_next;
    logic [lars_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [COL_W-1:0]              width;
    logic [COL_W-1:0]              c0, c1, c_inc;
    logic [lars_pkg::ROW_BITS-1:0] r0;

    // effective row width: zero acts as one, clamp to the row store depth
    always_comb begin
        if (cols_in_use == '0) begin
            width = COL_W'(1);
        end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
            width = COL_W'(MAX_COLS);
        end else begin
            width = COL_W'(cols_in_use);
        end
    end

    always_comb begin
        c0 = new_matrix ? '0 : col_reg;
        r0 = new_matrix ? '0 : row_reg;
        // width may have shrunk mid row
        c1 = (c0 >= width) ? '0 : c0;
        if ((c1 == '0) && (r0 != lars_pkg::ROW_MAX)) begin
            row_next = r0 + lars_pkg::ROW_BITS'(1);
        end else begin
            row_next = r0;
        end
        c_inc    = c1 + COL_W'(1);
        col_next = (c_inc >= width) ? '0 : c_inc;
        col           = c1;
        row           = row_next;
        ctl.fresh     = new_matrix;
        ctl.col_zero  = (c1 == '0);
        ctl.row_first = (row_next <= lars_pkg::ROW_BITS'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: design/lars_row_mem.sv
// previous-row score store with same-cycle write bypass
module lars_row_mem #(
    parameter int MAX_COLS   = 1024,
    parameter int SCORE_BITS = 15
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_COLS)-1:0] wr_addr,
    input  logic [SCORE_BITS-1:0]       wr_data,
    output logic [SCORE_BITS-1:0]       rd_data
);

    logic [SCORE_BITS-1:0] mem [MAX_COLS];
    logic [SCORE_BITS-1:0] rd_q_reg;
    logic [SCORE_BITS-1:0] fwd_data_reg;
    logic                  fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // a read that meets a write to the same entry takes the new score
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

FILE: design/lars_cell.sv
// cell score, direction and best-cell tracking, one item per cycle on which fire is high
module lars_cell #(
    parameter int SCORE_BITS = 15,
    parameter int COL_W      = 11
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  lars_pkg::cell_ctl_t            ctl,
    input  logic [COL_W-1:0]               col,
    input  logic [lars_pkg::ROW_BITS-1:0]  row,
    input  logic [lars_pkg::SYM_BITS-1:0]  ref_symbol,
    input  logic [lars_pkg::SYM_BITS-1:0]  query_symbol,
    input  logic signed [7:0]              match_add,
    input  logic signed [7:0]              mismatch_add,
    input  logic signed [7:0]              gap_add,
    input  logic [SCORE_BITS-1:0]          above_raw,
    output logic [SCORE_BITS-1:0]          cell_score,
    output lars_pkg::dir_t                 direction,
    output logic [SCORE_BITS-1:0]          best_score,
    output logic [lars_pkg::ROW_BITS-1:0]  best_row,
    output logic [COL_W-1:0]               best_col
);

    localparam int CW = SCORE_BITS + 2;
    localparam logic signed [CW-1:0] SCORE_MAX = {2'b00, {SCORE_BITS{1'b1}}};

    logic [SCORE_BITS-1:0]         left_reg, diag_reg;
    logic [SCORE_BITS-1:0]         best_val_reg;
    logic [lars_pkg::ROW_BITS-1:0] best_row_reg;
    logic [COL_W-1:0]              best_col_reg;

    logic signed [CW-1:0] above_c, diag_src, left_src, gap_x, pair_x;
    logic signed [CW-1:0] up_c, left_c, diag_c, pick;
    logic [SCORE_BITS-1:0] best_prev;
    logic                  new_best;

    always_comb begin
        above_c  = ctl.row_first ? '0 : $signed({2'b00, above_raw});
        diag_src = (ctl.row_first || ctl.col_zero) ? '0 : $signed({2'b00, diag_reg});
        left_src = ctl.col_zero ? '0 : $signed({2'b00, left_reg});
        gap_x    = CW'(gap_add);
        pair_x   = (ref_symbol == query_symbol) ? CW'(match_add) : CW'(mismatch_add);
        up_c     = above_c + gap_x;
        left_c   = left_src + gap_x;
        diag_c   = diag_src + pair_x;

        // ties go diagonal, then up, then left
        pick      = '0;
        direction = lars_pkg::DIR_NONE;
        if (diag_c > pick) begin
            pick      = diag_c;
            direction = lars_pkg::DIR_DIAG;
        end
        if (up_c > pick) begin
            pick      = up_c;
            direction = lars_pkg::DIR_UP;
        end
        if (left_c > pick) begin
            pick      = left_c;
            direction = lars_pkg::DIR_LEFT;
        end
        if (pick > SCORE_MAX) begin
            pick = SCORE_MAX;
        end
        cell_score = pick[SCORE_BITS-1:0];

        best_prev = ctl.fresh ? '0 : best_val_reg;
        new_best  = (cell_score > best_prev);
        if (new_best) begin
            best_score = cell_score;
            best_row   = row;
            best_col   = col + COL_W'(1);
        end else begin
            best_score = best_prev;
            best_row   = ctl.fresh ? '0 : best_row_reg;
            best_col   = ctl.fresh ? '0 : best_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            diag_reg     <= '0;
            best_val_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end else if (fire) begin
            left_reg     <= cell_score;
            diag_reg     <= above_c[SCORE_BITS-1:0];
            best_val_reg <= best_score;
            best_row_reg <= best_row;
            best_col_reg <= best_col;
        end
    end

endmodule

FILE: design/local_alignment_row_scorer_top.sv
// smith-waterman row scorer: one matrix cell in, one scored cell out
// an accepted item passes through the input stage, then the result register
// throughput: one item per cycle; row store read at accept, written as the item moves on
// stalls only when the result register is full and m_ready is low
// reset (aresetn low, synchronous) empties both stages, restores register defaults and
// makes the next item start a new matrix; the row store is not cleared
module local_alignment_row_scorer_top #(
    parameter int MAX_COLS   = 1024,
    parameter int SCORE_BITS = 15
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [1:0]                              cfg_index,
    input  logic [lars_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [lars_pkg::SYM_BITS-1:0]           s_ref_symbol,
    input  logic [lars_pkg::SYM_BITS-1:0]           s_query_symbol,
    input  logic                                    s_new_matrix,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [SCORE_BITS-1:0]                   m_cell_score,
    output logic [1:0]                              m_direction,
    output logic [SCORE_BITS-1:0]                   m_best_score,
    output logic [lars_pkg::ROW_BITS-1:0]           m_best_row,
    output logic [$clog2(MAX_COLS+1)-1:0]           m_best_col
);

    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int AW    = $clog2(MAX_COLS);

    logic signed [7:0]                  match_reg, mismatch_reg, gap_reg;
    logic [lars_pkg::CFG_DATA_BITS-1:0] cols_reg;

    logic                          accept, fire;
    logic [COL_W-1:0]              idx_col;
    logic [lars_pkg::ROW_BITS-1:0] idx_row;
    lars_pkg::cell_ctl_t           idx_ctl;

    logic                          s1_valid_reg;
    logic [lars_pkg::SYM_BITS-1:0] s1_ref_reg, s1_query_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [lars_pkg::ROW_BITS-1:0] s1_row_reg;
    lars_pkg::cell_ctl_t           s1_ctl_reg;

    logic [SCORE_BITS-1:0]         above_raw;
    logic [SCORE_BITS-1:0]         cell_score, best_score;
    lars_pkg::dir_t                direction;
    logic [lars_pkg::ROW_BITS-1:0] best_row;
    logic [COL_W-1:0]              best_col;

    logic                          m_valid_reg;
    logic [SCORE_BITS-1:0]         m_cell_reg, m_best_reg;
    logic [1:0]                    m_dir_reg;
    logic [lars_pkg::ROW_BITS-1:0] m_row_reg;
    logic [COL_W-1:0]              m_col_reg;

    assign fire    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg    <= lars_pkg::MATCH_RESET;
            mismatch_reg <= lars_pkg::MISMATCH_RESET;
            gap_reg      <= lars_pkg::GAP_RESET;
            cols_reg     <= lars_pkg::COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lars_pkg::CFG_MATCH:    match_reg    <= cfg_wdata[7:0];
                lars_pkg::CFG_MISMATCH: mismatch_reg <= cfg_wdata[7:0];
                lars_pkg::CFG_GAP:      gap_reg      <= cfg_wdata[7:0];
                lars_pkg::CFG_COLS:     cols_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lars_indexer #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_indexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .new_matrix  (s_new_matrix),
        .cols_in_use (cols_reg),
        .col         (idx_col),
        .row         (idx_row),
        .ctl         (idx_ctl)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ref_reg   <= s_ref_symbol;
            s1_query_reg <= s_query_symbol;
            s1_col_reg   <= idx_col;
            s1_row_reg   <= idx_row;
            s1_ctl_reg   <= idx_ctl;
        end
    end

    lars_row_mem #(
        .MAX_COLS   (MAX_COLS),
        .SCORE_BITS (SCORE_BITS)
    ) u_row_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (idx_col[AW-1:0]),
        .wr_en   (fire),
        .wr_addr (s1_col_reg[AW-1:0]),
        .wr_data (cell_score),
        .rd_data (above_raw)
    );

    lars_cell #(
        .SCORE_BITS (SCORE_BITS),
        .COL_W      (COL_W)
    ) u_cell (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .ctl            (s1_ctl_reg),
        .col            (s1_col_reg),
        .row            (s1_row_reg),
        .ref_symbol     (s1_ref_reg),
        .query_symbol   (s1_query_reg),
        .match_add      (match_reg),
        .mismatch_add   (mismatch_reg),
        .gap_add        (gap_reg),
        .above_raw      (above_raw),
        .cell_score     (cell_score),
        .direction      (direction),
        .best_score     (best_score),
        .best_row       (best_row),
        .best_col       (best_col)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_cell_reg <= cell_score;
            m_dir_reg  <= direction;
            m_best_reg <= best_score;
            m_row_reg  <= best_row;
            m_col_reg  <= best_col;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_score = m_cell_reg;
    assign m_direction  = m_dir_reg;
    assign m_best_score = m_best_reg;
    assign m_best_row   = m_row_reg;
    assign m_best_col   = m_col_reg;

endmodule

FILE: design/lars_checker.sv
// port-level checks on the scorer's result channel, bound to the top level
module lars_checker #(
    parameter int MAX_COLS   = 1024,
    parameter int SCORE_BITS = 15
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [SCORE_BITS-1:0]              m_cell_score,
    input logic [1:0]                         m_direction,
    input logic [SCORE_BITS-1:0]              m_best_score,
    input logic [lars_pkg::ROW_BITS-1:0]      m_best_row,
    input logic [$clog2(MAX_COLS+1)-1:0]      m_best_col
);

    // a stalled item stays valid and keeps its cell and best scores
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_score) && $stable(m_best_score))
        else $error("result item changed while stalled");

    // the best score already includes this cell
    a_best_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_best_score >= m_cell_score)
        else $error("best score below cell score");

    // no predecessor exactly when the score is zero
    a_dir_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_direction == lars_pkg::DIR_NONE) == (m_cell_score == '0)))
        else $error("direction and zero score disagree");

    // a positive best has a position
    a_best_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_best_score != '0) |-> (m_best_row != '0) && (m_best_col != '0))
        else $error("best score without a position");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind local_alignment_row_scorer_top lars_checker #(
    .MAX_COLS   (MAX_COLS),
    .SCORE_BITS (SCORE_BITS)
) u_lars_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_score (m_cell_score),
    .m_direction  (m_direction),
    .m_best_score (m_best_score),
    .m_best_row   (m_best_row),
    .m_best_col   (m_best_col)
);
